// File: src/fapg_pkg.sv
package fapg_pkg;

    // Number formats
    localparam int FRAC_BITS    = 28;
    localparam int CORDIC_STEPS = 24;
    localparam int ACC_W        = FRAC_BITS + 64;   // product bits kept by the multiplier
    localparam int TRIG_W       = 34;               // CORDIC datapath, Q1.30 plus headroom
    localparam int ATAN_N       = 32;
    localparam int ATAN_W       = 5;
    localparam int NOISE_W      = 19;
    localparam int CNT_W        = 24;
    localparam int TSTEP_W      = 31;
    localparam int T_W          = CNT_W + TSTEP_W;

    typedef logic [ACC_W-1:0] t_acc;
    typedef logic signed [TRIG_W-1:0] t_trig;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_X_SX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_X_CY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_X_ST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_Y_CX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_Y_SY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_Y_CT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_LIM = 3'd7;

    localparam logic [31:0]        RST_AMP_X_SX  = 32'(-563714458);
    localparam logic [31:0]        RST_AMP_X_CY  = 32'd375809638;
    localparam logic [31:0]        RST_AMP_X_ST  = 32'd295279002;
    localparam logic [31:0]        RST_AMP_Y_CX  = 32'd295279002;
    localparam logic [31:0]        RST_AMP_Y_SY  = 32'd322122547;
    localparam logic [31:0]        RST_AMP_Y_CT  = 32'd241591910;
    localparam logic [TSTEP_W-1:0] RST_TIME_STEP = 31'd13421773;
    localparam logic [CNT_W-1:0]   RST_POINT_LIM = 24'd5000000;

    // Turn conversion factors, Q0.64
    localparam logic [63:0]  C10 = 64'h28BE60DB9391054A;
    localparam logic [127:0] P04 = {64'd0, C10} * {64'd0, 64'h6666666666666666};
    localparam logic [127:0] P07 = {64'd0, C10} * {64'd0, 64'hB333333333333333};
    localparam logic [127:0] P01 = {64'd0, C10} * {64'd0, 64'h1999999999999999};
    localparam logic [63:0]  C04 = P04[127:64];
    localparam logic [63:0]  C07 = P07[127:64];
    localparam logic [63:0]  C11 = C10 + P01[127:64];

    // CORDIC gain-compensated start value, Q1.30
    localparam logic [31:0] CORDIC_K = 32'd652032874;

    // Arctangent of 2^-i in Q0.32 turns
    localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

endpackage

// File: src/fapg_in_if.sv
interface fapg_in_if;
    logic                          valid;
    logic                          ready;
    logic [fapg_pkg::NOISE_W-1:0]  noise_x;
    logic [fapg_pkg::NOISE_W-1:0]  noise_y;

    modport source (output valid, output noise_x, output noise_y, input ready);
    modport sink   (input valid, input noise_x, input noise_y, output ready);
endinterface

// File: src/fapg_out_if.sv
interface fapg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// File: src/forced_attractor_point_generator.sv
// Forced attractor point generator. Each input transaction carries two noise values; while
// fewer than point_limit points have been produced it returns the current point and then
// moves it one step of the attractor, otherwise it returns nothing and changes nothing.
// Transactions are handled one at a time: six angle evaluations on a single CORDIC unit,
// four angle conversions, six amplitude products and three time products on a single
// 32x32 multiplier used as four partial products. Input ready is low while a transaction
// is processed and also while a finished point waits in the output register. Configuration
// writes take effect at once and belong only in idle periods.
module forced_attractor_point_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fapg_in_if.sink                         i_in,
    fapg_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [fapg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fapg_pkg::CFG_W-1:0]      i_cfg_data
);
    import fapg_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_A_GO  = 4'd1;
    localparam logic [3:0] S_A_W   = 4'd2;
    localparam logic [3:0] S_C_GO  = 4'd3;
    localparam logic [3:0] S_C_W   = 4'd4;
    localparam logic [3:0] S_P_GO  = 4'd5;
    localparam logic [3:0] S_P_W   = 4'd6;
    localparam logic [3:0] S_T_GO  = 4'd7;
    localparam logic [3:0] S_T_W   = 4'd8;
    localparam logic [3:0] S_H_GO  = 4'd9;
    localparam logic [3:0] S_H_W   = 4'd10;

    // Which stored trig value each amplitude product uses
    localparam logic [2:0] TRIG_SEL [6] = '{3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd5};

    // Configuration registers
    logic [31:0]        r_amp_x_sx, r_amp_x_cy, r_amp_x_st;
    logic [31:0]        r_amp_y_cx, r_amp_y_sy, r_amp_y_ct;
    logic [TSTEP_W-1:0] r_time_step;
    logic [CNT_W-1:0]   r_point_limit;

    // Attractor state
    logic [31:0]        r_pos_x, r_pos_y;
    logic [31:0]        r_ph_sin, r_ph_cos;
    logic [CNT_W-1:0]   r_step_count;

    // Sequencer and working registers
    logic [3:0]         r_state;
    logic [2:0]         r_job;
    logic [NOISE_W-1:0] r_noise_x, r_noise_y;
    logic [31:0]        r_turn;
    t_trig              r_trig [6];
    logic signed [35:0] r_sum_x, r_sum_y;
    logic [T_W-1:0]     r_t;
    logic               r_out_v;
    logic [31:0]        r_out_x, r_out_y;

    logic               w_accept;
    logic               w_mul_go;
    logic [63:0]        w_mul_a, w_mul_b;
    logic               w_mul_done;
    t_acc               w_prod;
    logic               w_cor_go;
    logic [31:0]        w_cor_ph;
    logic               w_cor_done;
    t_trig              w_cos, w_sin;
    logic [32:0]        w_amp;
    logic signed [35:0] w_term;
    logic signed [35:0] w_fin_y;
    logic [31:0]        w_turns;

    fapg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_go),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    fapg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_go),
        .i_phase (w_cor_ph),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Handshake
    assign i_in.ready   = (r_state == S_IDLE) && (!r_out_v || o_out.ready);
    assign w_accept     = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_v;
    assign o_out.point_x = r_out_x;
    assign o_out.point_y = r_out_y;

    assign w_turns  = w_prod[FRAC_BITS+63:FRAC_BITS+32];
    assign w_term   = 36'(signed'(w_prod[63:30]));
    assign w_fin_y  = r_sum_y + w_term;
    assign w_cor_go = (r_state == S_C_GO);
    assign w_mul_go = (r_state == S_A_GO) || (r_state == S_P_GO)
                   || (r_state == S_T_GO) || (r_state == S_H_GO);

    // CORDIC angle: converted position or held time phase
    always_comb begin
        unique case (r_job)
            3'd4:    w_cor_ph = r_ph_sin;
            3'd5:    w_cor_ph = r_ph_cos;
            default: w_cor_ph = r_turn;
        endcase
    end

    // Amplitude for each product, noise on the two sine terms
    always_comb begin
        unique case (r_job)
            3'd0:    w_amp = {r_amp_x_sx[31], r_amp_x_sx} + {14'd0, r_noise_x};
            3'd1:    w_amp = {r_amp_x_cy[31], r_amp_x_cy};
            3'd2:    w_amp = {r_amp_x_st[31], r_amp_x_st};
            3'd3:    w_amp = {r_amp_y_cx[31], r_amp_y_cx};
            3'd4:    w_amp = {r_amp_y_sy[31], r_amp_y_sy} + {14'd0, r_noise_y};
            default: w_amp = {r_amp_y_ct[31], r_amp_y_ct};
        endcase
    end

    // Multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_A_GO: begin
                w_mul_a = 64'(signed'(r_job[1] ? r_pos_y : r_pos_x));
                unique case (r_job)
                    3'd0:       w_mul_b = C04;
                    3'd1, 3'd2: w_mul_b = C11;
                    default:    w_mul_b = C10;
                endcase
            end
            S_P_GO: begin
                w_mul_a = 64'(signed'(w_amp));
                w_mul_b = 64'(r_trig[TRIG_SEL[r_job]]);
            end
            S_T_GO: begin
                w_mul_a = 64'(r_step_count);
                w_mul_b = 64'(r_time_step);
            end
            S_H_GO: begin
                w_mul_a = 64'(r_t);
                w_mul_b = r_job[0] ? C07 : C10;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_x_sx    <= RST_AMP_X_SX;
            r_amp_x_cy    <= RST_AMP_X_CY;
            r_amp_x_st    <= RST_AMP_X_ST;
            r_amp_y_cx    <= RST_AMP_Y_CX;
            r_amp_y_sy    <= RST_AMP_Y_SY;
            r_amp_y_ct    <= RST_AMP_Y_CT;
            r_time_step   <= RST_TIME_STEP;
            r_point_limit <= RST_POINT_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AMP_X_SX:  r_amp_x_sx    <= i_cfg_data;
                REG_AMP_X_CY:  r_amp_x_cy    <= i_cfg_data;
                REG_AMP_X_ST:  r_amp_x_st    <= i_cfg_data;
                REG_AMP_Y_CX:  r_amp_y_cx    <= i_cfg_data;
                REG_AMP_Y_SY:  r_amp_y_sy    <= i_cfg_data;
                REG_AMP_Y_CT:  r_amp_y_ct    <= i_cfg_data;
                REG_TIME_STEP: r_time_step   <= i_cfg_data[TSTEP_W-1:0];
                default:       r_point_limit <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // Sequencer and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_job        <= '0;
            r_out_v      <= 1'b0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_ph_sin     <= '0;
            r_ph_cos     <= '0;
            r_step_count <= '0;
        end else begin
            if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (r_step_count < r_point_limit)) begin
                        r_out_v <= 1'b1;
                        r_job   <= '0;
                        r_state <= S_A_GO;
                    end
                end
                S_A_GO: r_state <= S_A_W;
                S_A_W: begin
                    if (w_mul_done) begin
                        r_state <= S_C_GO;
                    end
                end
                S_C_GO: r_state <= S_C_W;
                S_C_W: begin
                    if (w_cor_done) begin
                        if (r_job == 3'd5) begin
                            r_job   <= '0;
                            r_state <= S_P_GO;
                        end else begin
                            r_job   <= r_job + 3'd1;
                            r_state <= (r_job < 3'd3) ? S_A_GO : S_C_GO;
                        end
                    end
                end
                S_P_GO: r_state <= S_P_W;
                S_P_W: begin
                    if (w_mul_done) begin
                        if (r_job == 3'd5) begin
                            r_pos_x <= sat32(r_sum_x);
                            r_pos_y <= sat32(w_fin_y);
                            r_state <= S_T_GO;
                        end else begin
                            r_job   <= r_job + 3'd1;
                            r_state <= S_P_GO;
                        end
                    end
                end
                S_T_GO: r_state <= S_T_W;
                S_T_W: begin
                    if (w_mul_done) begin
                        r_job   <= '0;
                        r_state <= S_H_GO;
                    end
                end
                S_H_GO: r_state <= S_H_W;
                S_H_W: begin
                    if (w_mul_done) begin
                        if (r_job[0]) begin
                            r_ph_cos     <= w_turns;
                            r_step_count <= r_step_count + 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_ph_sin <= w_turns;
                            r_job    <= 3'd1;
                            r_state  <= S_H_GO;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_noise_x <= i_in.noise_x;
            r_noise_y <= i_in.noise_y;
            r_out_x   <= r_pos_x;
            r_out_y   <= r_pos_y;
        end
        if ((r_state == S_A_W) && w_mul_done) begin
            r_turn <= w_turns;
        end
        if ((r_state == S_C_W) && w_cor_done) begin
            unique case (r_job)
                3'd1, 3'd2, 3'd5: r_trig[r_job] <= w_cos;
                default:          r_trig[r_job] <= w_sin;
            endcase
        end
        if ((r_state == S_P_W) && w_mul_done) begin
            unique case (r_job)
                3'd0:       r_sum_x <= w_term;
                3'd1, 3'd2: r_sum_x <= r_sum_x + w_term;
                3'd3:       r_sum_y <= w_term;
                default:    r_sum_y <= w_fin_y;
            endcase
        end
        if ((r_state == S_T_W) && w_mul_done) begin
            r_t <= w_prod[T_W-1:0];
        end
    end

endmodule

// File: src/fapg_mul.sv
module fapg_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_a,     // two's complement
    input  logic [63:0]         i_b,     // unsigned
    output logic                o_done,
    output fapg_pkg::t_acc      o_prod   // low ACC_W bits of signed a times unsigned b
);
    import fapg_pkg::*;

    logic [1:0]  r_k;
    logic        r_run;
    logic        r_pv;
    logic [1:0]  r_pk;
    logic [63:0] r_pp;
    logic        r_done;
    logic [63:0] r_a;
    logic [63:0] r_b;
    t_acc        r_acc;
    logic [31:0] w_ah;
    logic [31:0] w_bh;
    t_acc        w_pp_sh;

    // Partial product order: a0b0, a0b1, a1b0, a1b1
    assign w_ah = r_k[1] ? r_a[63:32] : r_a[31:0];
    assign w_bh = r_k[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        unique case (r_pk)
            2'd0:    w_pp_sh = t_acc'(r_pp);
            2'd3:    w_pp_sh = t_acc'(r_pp) << 64;
            default: w_pp_sh = t_acc'(r_pp) << 32;
        endcase
    end

    // Issue one 32x32 product per cycle, accumulate it the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= r_pv && !r_run;
            r_pv   <= r_run;
            if (i_start) begin
                r_run <= 1'b1;
                r_k   <= 2'd0;
            end else if (r_run) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp <= w_ah * w_bh;
        r_pk <= r_k;
        if (i_start) begin
            // operands are only valid in the start cycle, hold them
            r_a   <= i_a;
            r_b   <= i_b;
            // signed a: remove the b*2^64 term the unsigned view adds
            r_acc <= i_a[63] ? (t_acc'(0) - (t_acc'(i_b) << 64)) : t_acc'(0);
        end else if (r_pv) begin
            r_acc <= r_acc + w_pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: src/fapg_cordic.sv
module fapg_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_phase,  // Q0.32 turns
    output logic                o_done,
    output fapg_pkg::t_trig     o_cos,
    output fapg_pkg::t_trig     o_sin
);
    import fapg_pkg::*;

    t_trig             r_x;
    t_trig             r_y;
    t_trig             r_z;
    logic [1:0]        r_q;
    logic [ATAN_W-1:0] r_i;
    logic              r_run;
    logic              r_done;
    logic [1:0]        w_q;
    logic [31:0]       w_ru;
    logic [31:0]       w_sum;
    t_trig             w_xs;
    t_trig             w_ys;
    t_trig             w_at;

    // Nearest quarter turn and residual
    assign w_sum = i_phase + 32'h2000_0000;
    assign w_q   = w_sum[31:30];
    assign w_ru  = i_phase - {w_q, 30'd0};

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = t_trig'({2'b00, ATAN_TURNS[r_i]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_i   <= '0;
            end else if (r_run) begin
                r_i <= r_i + 1'b1;
                if (r_i == ATAN_W'(CORDIC_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One micro-rotation per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= t_trig'({2'b00, CORDIC_K});
            r_y <= '0;
            r_z <= t_trig'(signed'(w_ru));
            r_q <= w_q;
        end else if (r_run) begin
            if (!r_z[TRIG_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    // Apply the quarter turn
    always_comb begin
        unique case (r_q)
            2'd0: begin o_cos = r_x;  o_sin = r_y;  end
            2'd1: begin o_cos = -r_y; o_sin = r_x;  end
            2'd2: begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y; o_sin = -r_x; end
        endcase
    end

    assign o_done = r_done;

endmodule

// File: tb/sv/tb_forced_attractor_point_generator.sv
`timescale 1ns / 100ps

module tb_forced_attractor_point_generator;
    import fapg_pkg::*;

    localparam int STALL_LIMIT   = 20000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES = 400;
    localparam logic [NOISE_W-1:0] NOISE_MAX = '1;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
    } point_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    fapg_in_if  in_if ();
    fapg_out_if out_if ();

    forced_attractor_point_generator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the generator: configuration and attractor state
    logic [31:0]        amp_x_sx, amp_x_cy, amp_x_st, amp_y_cx, amp_y_sy, amp_y_ct;
    logic [TSTEP_W-1:0] time_step;
    logic [CNT_W-1:0]   point_limit;
    logic [31:0]        pos_x, pos_y, phase_t, phase_07t;
    logic [CNT_W-1:0]   step_count;

    point_t pending_points[$];
    int     n_errors;
    int     n_points;
    int     n_steps;
    bit     out_calm;
    bit     in_calm;

    // Value times Q0.64 factor, keeping the turn fraction
    function automatic logic [31:0] to_angle(longint v, logic [63:0] coef);
        logic signed [127:0] prod;
        prod = $signed({{64{v[63]}}, v}) * $signed({64'd0, coef});
        return prod[FRAC_BITS+63 -: 32];
    endfunction

    // Quarter-turn split, then CORDIC rotation of the residual
    function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                    output longint s);
        logic [1:0]  quad;
        logic [31:0] resid;
        longint z, x, y, nx;
        quad  = 2'((ang + 32'h20000000) >> 30);
        resid = ang - {quad, 30'd0};
        z = longint'($signed(resid));
        x = longint'(CORDIC_K);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_TURNS[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_TURNS[i]);
            end
            x = nx;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // One attractor step below the point limit: queue the current point, then move it
    function automatic void advance_point(logic [NOISE_W-1:0] nzx, logic [NOISE_W-1:0] nzy);
        longint px, py, c, s, sin_x04, cos_x11, cos_y11, sin_y10, sin_t, cos_t, nx, ny, t;
        if (step_count >= point_limit) return;
        pending_points.push_back('{x: pos_x, y: pos_y});
        px = longint'($signed(pos_x));
        py = longint'($signed(pos_y));
        sin_cos(to_angle(px, C04), c, sin_x04);
        sin_cos(to_angle(px, C11), cos_x11, s);
        sin_cos(to_angle(py, C11), cos_y11, s);
        sin_cos(to_angle(py, C10), c, sin_y10);
        sin_cos(phase_t, c, sin_t);
        sin_cos(phase_07t, cos_t, s);
        nx = (((longint'($signed(amp_x_sx)) + longint'(nzx)) * sin_x04) >>> 30)
           + ((longint'($signed(amp_x_cy)) * cos_y11) >>> 30)
           + ((longint'($signed(amp_x_st)) * sin_t) >>> 30);
        ny = ((longint'($signed(amp_y_cx)) * cos_x11) >>> 30)
           + (((longint'($signed(amp_y_sy)) + longint'(nzy)) * sin_y10) >>> 30)
           + ((longint'($signed(amp_y_ct)) * cos_t) >>> 30);
        t = longint'(step_count) * longint'(time_step);
        pos_x      = clamp32(nx);
        pos_y      = clamp32(ny);
        phase_t    = to_angle(t, C10);
        phase_07t  = to_angle(t, C07);
        step_count = step_count + 1'b1;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result checker
    always @(posedge i_clk) begin
        point_t exp_pt;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_points++;
            if (pending_points.size() == 0) begin
                $error("unexpected point x=%0d y=%0d", out_if.point_x, out_if.point_y);
                n_errors++;
            end else begin
                exp_pt = pending_points.pop_front();
                if (out_if.point_x !== exp_pt.x) begin
                    $error("point_x expected %0d got %0d", $signed(exp_pt.x), out_if.point_x);
                    n_errors++;
                end
                if (out_if.point_y !== exp_pt.y) begin
                    $error("point_y expected %0d got %0d", $signed(exp_pt.y), out_if.point_y);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on idle cycles
    always @(posedge i_clk) begin
        int idle_cycles;
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_forced_attractor_point_generator NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Receiver back-pressure
    always @(negedge i_clk) begin
        int hold;
        if (!i_rst_n || out_calm) begin
            out_if.ready = 1'b1;
            hold = 0;
        end else if (hold > 0) begin
            out_if.ready = 1'b0;
            hold--;
        end else begin
            out_if.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) hold = pick_gap();
        end
    end

    // Send one noise transaction and predict on acceptance
    task automatic send_noise(logic [NOISE_W-1:0] nzx, logic [NOISE_W-1:0] nzy);
        int gap;
        @(negedge i_clk);
        in_if.valid   = 1'b1;
        in_if.noise_x = nzx;
        in_if.noise_y = nzy;
        do @(posedge i_clk); while (!in_if.ready);
        advance_point(nzx, nzy);
        n_steps++;
        gap = in_calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            REG_AMP_X_SX:  amp_x_sx = val;
            REG_AMP_X_CY:  amp_x_cy = val;
            REG_AMP_X_ST:  amp_x_st = val;
            REG_AMP_Y_CX:  amp_y_cx = val;
            REG_AMP_Y_SY:  amp_y_sy = val;
            REG_AMP_Y_CT:  amp_y_ct = val;
            REG_TIME_STEP: time_step = val[TSTEP_W-1:0];
            REG_POINT_LIM: point_limit = val[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [NOISE_W-1:0] rand_noise();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return NOISE_MAX;
            2: return NOISE_W'($urandom_range(0, 268435));
            default: return NOISE_W'($urandom);
        endcase
    endfunction

    // Amplitude: mostly moderate, sometimes full range or an extreme
    function automatic logic [31:0] rand_amp();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h40000000)) - 32'sh20000000);
        endcase
    endfunction

    // Default configuration out of reset, noise at its corners, then random noise
    task automatic test_reset_defaults();
        send_noise('0, '0);
        send_noise(NOISE_MAX, NOISE_MAX);
        send_noise('0, NOISE_MAX);
        send_noise(NOISE_MAX, '0);
        repeat (4) send_noise(rand_noise(), rand_noise());
        drain();
    endtask

    // Extreme amplitudes and time step drive the coordinates into saturation
    task automatic test_saturation();
        for (int r = REG_AMP_X_SX; r <= REG_AMP_Y_CT; r++)
            write_reg(CFG_IDX_W'(r), 32'h7FFFFFFF);
        write_reg(REG_TIME_STEP, 32'h7FFFFFFF);
        repeat (4) send_noise(NOISE_MAX, NOISE_MAX);
        drain();
        for (int r = REG_AMP_X_SX; r <= REG_AMP_Y_CT; r++)
            write_reg(CFG_IDX_W'(r), 32'h80000000);
        write_reg(REG_TIME_STEP, 32'd0);
        repeat (4) send_noise('0, '0);
        drain();
    endtask

    // Limit of zero, then a limit reached mid-stream
    task automatic test_point_limit();
        write_reg(REG_POINT_LIM, 32'd0);
        repeat (2) send_noise(NOISE_MAX, '0);
        drain();
        write_reg(REG_POINT_LIM, 32'(step_count) + 32'd2);
        repeat (4) send_noise(rand_noise(), rand_noise());
        drain();
    endtask

    // Random configurations, each followed by a run of random steps
    task automatic test_random_walk();
        for (int ph = 0; ph < 10; ph++) begin
            for (int r = REG_AMP_X_SX; r <= REG_AMP_Y_CT; r++)
                write_reg(CFG_IDX_W'(r), rand_amp());
            case (ph % 4)
                0: write_reg(REG_TIME_STEP, 32'd0);
                1: write_reg(REG_TIME_STEP, 32'h7FFFFFFF);
                default: write_reg(REG_TIME_STEP, $urandom);
            endcase
            write_reg(REG_POINT_LIM, 32'hFFFFFF);
            in_calm  = (ph == 3);
            out_calm = (ph == 3);
            repeat (140) send_noise(rand_noise(), rand_noise());
            in_calm  = 1'b0;
            out_calm = 1'b0;
            drain();
        end
        // run into the limit with random traffic behind it
        write_reg(REG_POINT_LIM, 32'(step_count) + 32'd20);
        repeat (40) send_noise(rand_noise(), rand_noise());
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.noise_x = '0;
        in_if.noise_y = '0;
        out_if.ready  = 1'b1;
        n_errors = 0;
        n_points = 0;
        n_steps  = 0;
        in_calm  = 1'b0;
        out_calm = 1'b0;
        amp_x_sx = RST_AMP_X_SX; amp_x_cy = RST_AMP_X_CY; amp_x_st = RST_AMP_X_ST;
        amp_y_cx = RST_AMP_Y_CX; amp_y_sy = RST_AMP_Y_SY; amp_y_ct = RST_AMP_Y_CT;
        time_step   = RST_TIME_STEP;
        point_limit = RST_POINT_LIM;
        pos_x = '0; pos_y = '0; phase_t = '0; phase_07t = '0; step_count = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_saturation();
        test_point_limit();
        test_random_walk();

        $display("Sent %0d noise transactions, checked %0d points, final step count %0d.",
                 n_steps, n_points, step_count);
        $display("Covered defaults, saturation, zero and reached limits, random amplitudes.");
        if (n_errors == 0)
            $display("tb_forced_attractor_point_generator OK");
        else
            $display("tb_forced_attractor_point_generator NOT OK");
        $finish;
    end

endmodule

// File: sim.f
src/fapg_pkg.sv
src/fapg_in_if.sv
src/fapg_out_if.sv
src/fapg_mul.sv
src/fapg_cordic.sv
src/forced_attractor_point_generator.sv
tb/sv/tb_forced_attractor_point_generator.sv
